// ===== rtl/brda_pkg.sv =====
// Package for the BCD clock decoder: configuration, time types and the month table.
package brda_pkg;

    localparam logic [2:0] ADDR_DST_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_ZONE_OFFSET = 3'd4;
    localparam int unsigned REG_SEL_BIT = 2;

    localparam logic [7:0] MONTH_MARCH = 8'd3;
    localparam logic [7:0] MONTH_OCTOBER = 8'd10;
    localparam logic [7:0] WEEKDAY_SUNDAY = 8'd7;
    localparam logic [7:0] HOURS_PER_DAY = 8'd24;
    localparam logic [7:0] DAYS_IN_MARCH = 8'd31;
    localparam logic [11:0] YEAR_BASE = 12'd2000;

    typedef struct packed {
        logic       dst_enable;
        logic [4:0] zone_offset_hours;
    } t_cfg;

    typedef struct packed {
        logic [7:0] hour;
        logic [7:0] weekday;
        logic [7:0] day;
        logic [7:0] month;
    } t_time;

    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0000, b[7:4]};
        return {4'b0000, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    function automatic logic [7:0] month_length(input logic [7:0] month);
        logic [7:0] len;
        case (month) inside
            8'd2: len = 8'd28;
            8'd4, 8'd6, 8'd9, 8'd11: len = 8'd30;
            default: len = 8'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/brda_adjust.sv =====
// Summer-time decision and one-hour rollover on a decoded date and time.
module brda_adjust (
    input  brda_pkg::t_cfg  i_cfg,
    input  brda_pkg::t_time i_time,
    output brda_pkg::t_time o_time,
    output logic            o_summer
);

    logic signed [9:0] hour_minus_zone;
    logic signed [9:0] days_left;
    logic              summer;
    logic [7:0]        hour_inc;
    logic [7:0]        day_inc;
    logic              in_season;

    assign hour_minus_zone = $signed({2'b00, i_time.hour})
                           - $signed({{5{i_cfg.zone_offset_hours[4]}}, i_cfg.zone_offset_hours});
    assign days_left = $signed({2'b00, brda_pkg::DAYS_IN_MARCH})
                     - $signed({2'b00, i_time.day})
                     + $signed({2'b00, i_time.weekday});

    always_comb begin
        summer = 1'b0;
        if (i_time.month > brda_pkg::MONTH_MARCH && i_time.month < brda_pkg::MONTH_OCTOBER) begin
            summer = 1'b1;
        end else if (i_time.month == brda_pkg::MONTH_MARCH && i_time.day > 8'd24) begin
            if (i_time.weekday == brda_pkg::WEEKDAY_SUNDAY) begin
                summer = hour_minus_zone > 10'sd0;
            end else begin
                summer = days_left <= 10'sd7;
            end
        end else if (i_time.month == brda_pkg::MONTH_OCTOBER && i_time.day < 8'd25) begin
            summer = 1'b1;
        end else if (i_time.month == brda_pkg::MONTH_OCTOBER) begin
            if (i_time.weekday == brda_pkg::WEEKDAY_SUNDAY) begin
                summer = hour_minus_zone < 10'sd1;
            end else begin
                summer = days_left >= 10'sd7;
            end
        end
        summer = summer & i_cfg.dst_enable;
    end

    assign hour_inc = i_time.hour + {7'd0, summer};
    assign day_inc = i_time.day + 8'd1;
    assign in_season = i_time.month >= brda_pkg::MONTH_MARCH
                    && i_time.month <= brda_pkg::MONTH_OCTOBER;

    always_comb begin
        o_time = i_time;
        o_time.hour = hour_inc;
        if (i_cfg.dst_enable && in_season && hour_inc >= brda_pkg::HOURS_PER_DAY) begin
            o_time.hour = hour_inc - brda_pkg::HOURS_PER_DAY;
            if (day_inc > brda_pkg::month_length(i_time.month)) begin
                o_time.day = 8'd1;
                o_time.month = i_time.month + 8'd1;
            end else begin
                o_time.day = day_inc;
            end
            if (i_time.weekday >= brda_pkg::WEEKDAY_SUNDAY) begin
                o_time.weekday = 8'd1;
            end else begin
                o_time.weekday = i_time.weekday + 8'd1;
            end
        end
    end

    assign o_summer = summer;

endmodule

// ===== rtl/bcd_rtc_dst_adjust.sv =====
// Top level of the BCD clock decoder with summer-time adjustment.
//
// Channel   Direction  Handshake                      Payload
// request   in         start while busy is low        i_sec_bcd .. i_year_bcd
// result    out        o_valid strobe, one cycle      o_second .. o_summer_time
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A request is decoded into a register, then adjusted into the result register.
// The result strobe follows the taken request through r_v1 and then o_valid.
// busy stays low, so a request is taken every cycle.
// Reset clears both valid stages and sets both configuration registers to zero.
// The receiver cannot stall the results.
module bcd_rtc_dst_adjust (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_sec_bcd,
    input  logic [7:0]  i_min_bcd,
    input  logic [7:0]  i_hour_bcd,
    input  logic [7:0]  i_weekday_raw,
    input  logic [7:0]  i_day_bcd,
    input  logic [7:0]  i_month_bcd,
    input  logic [7:0]  i_year_bcd,
    output logic        o_valid,
    output logic [7:0]  o_second,
    output logic [7:0]  o_minute,
    output logic [7:0]  o_hour_out,
    output logic [7:0]  o_weekday_out,
    output logic [7:0]  o_day_out,
    output logic [7:0]  o_month_out,
    output logic [11:0] o_year_out,
    output logic        o_summer_time,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    brda_pkg::t_cfg  r_cfg;
    logic            r_v1;
    logic [7:0]      r_sec;
    logic [7:0]      r_min;
    logic [11:0]     r_year;
    brda_pkg::t_time r_time;
    brda_pkg::t_time adj_time;
    logic            adj_summer;
    logic            cfg_write;
    logic            accept;

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign accept = start & ~busy;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            if (paddr[brda_pkg::REG_SEL_BIT] == brda_pkg::ADDR_ZONE_OFFSET[brda_pkg::REG_SEL_BIT]) begin
                r_cfg.zone_offset_hours <= pwdata[4:0];
            end else begin
                r_cfg.dst_enable <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[brda_pkg::REG_SEL_BIT] == brda_pkg::ADDR_ZONE_OFFSET[brda_pkg::REG_SEL_BIT]) begin
            prdata = {27'd0, r_cfg.zone_offset_hours};
        end else begin
            prdata = {31'd0, r_cfg.dst_enable};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= accept;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sec <= brda_pkg::bcd_decode(i_sec_bcd);
            r_min <= brda_pkg::bcd_decode(i_min_bcd);
            r_year <= brda_pkg::YEAR_BASE + {4'd0, brda_pkg::bcd_decode(i_year_bcd)};
            r_time.hour <= brda_pkg::bcd_decode(i_hour_bcd);
            r_time.weekday <= i_weekday_raw;
            r_time.day <= brda_pkg::bcd_decode(i_day_bcd);
            r_time.month <= brda_pkg::bcd_decode(i_month_bcd);
        end
    end

    brda_adjust u_adjust (
        .i_cfg    (r_cfg),
        .i_time   (r_time),
        .o_time   (adj_time),
        .o_summer (adj_summer)
    );

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            o_second <= r_sec;
            o_minute <= r_min;
            o_year_out <= r_year;
            o_hour_out <= adj_time.hour;
            o_weekday_out <= adj_time.weekday;
            o_day_out <= adj_time.day;
            o_month_out <= adj_time.month;
            o_summer_time <= adj_summer;
        end
    end

    a_valid_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_v1))
        else $error("result strobe without a request two cycles earlier");

    a_summer_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_summer_time) |-> $past(r_cfg.dst_enable))
        else $error("summer time flagged while the rule is disabled");

    a_year_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_out >= brda_pkg::YEAR_BASE))
        else $error("decoded year below the base year");

    a_weekday_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hour_out + 8'd24 == $past(r_time.hour) + {7'd0, o_summer_time}))
            |-> (o_weekday_out != 8'd0))
        else $error("weekday rolled over to zero");

endmodule

// ===== dv/rtc_decode_checker.sv =====
// Checker for the BCD clock decoder: predicts each decoded time and compares it with the result.
module rtc_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  i_sec_bcd,
    input  logic [7:0]  i_min_bcd,
    input  logic [7:0]  i_hour_bcd,
    input  logic [7:0]  i_weekday_raw,
    input  logic [7:0]  i_day_bcd,
    input  logic [7:0]  i_month_bcd,
    input  logic [7:0]  i_year_bcd,
    input  logic        o_valid,
    input  logic [7:0]  o_second,
    input  logic [7:0]  o_minute,
    input  logic [7:0]  o_hour_out,
    input  logic [7:0]  o_weekday_out,
    input  logic [7:0]  o_day_out,
    input  logic [7:0]  o_month_out,
    input  logic [11:0] o_year_out,
    input  logic        o_summer_time,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUNDAY = 7;
    localparam int MARCH = 3;
    localparam int OCTOBER = 10;

    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  weekday;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
        logic        summer;
    } t_rtc_time;

    int        month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic      dst_on = 1'b0;
    logic [4:0] zone_hours = 5'd0;
    t_rtc_time expected_times [$];
    int        fails = 0;
    int        pending = 0;

    assign fail_count = fails;
    assign pending_count = pending;

    function automatic int bcd_to_int(input logic [7:0] b);
        return int'(b[3:0]) + 10 * int'(b[7:4]);
    endfunction

    function automatic t_rtc_time decode_and_adjust(
        input logic [7:0] sec_b, min_b, hour_b, wday_b, day_b, mon_b, year_b);
        int        hour;
        int        wday;
        int        day;
        int        mon;
        int        zone;
        bit        summer;
        t_rtc_time t;
        hour = bcd_to_int(hour_b);
        wday = int'(wday_b);
        day = bcd_to_int(day_b);
        mon = bcd_to_int(mon_b);
        zone = int'($signed(zone_hours));
        summer = 1'b0;
        if (dst_on) begin
            if (mon > MARCH && mon < OCTOBER) begin
                summer = 1'b1;
            end else if (mon == MARCH && day > 24) begin
                summer = (wday == SUNDAY) ? (hour - zone > 0) : (31 - day + wday <= 7);
            end else if (mon == OCTOBER && day < 25) begin
                summer = 1'b1;
            end else if (mon == OCTOBER) begin
                summer = (wday == SUNDAY) ? (hour - zone < 1) : (31 - day + wday >= 7);
            end
            if (summer) begin
                hour++;
            end
            if (mon >= MARCH && mon <= OCTOBER && hour >= 24) begin
                hour -= 24;
                day++;
                if (day > month_days[mon - 1]) begin
                    day = 1;
                    mon++;
                end
                wday++;
                if (wday > 7) begin
                    wday = 1;
                end
            end
        end
        t.second = 8'(bcd_to_int(sec_b));
        t.minute = 8'(bcd_to_int(min_b));
        t.hour = 8'(hour);
        t.weekday = 8'(wday);
        t.day = 8'(day);
        t.month = 8'(mon);
        t.year = 12'(bcd_to_int(year_b) + 2000);
        t.summer = summer;
        return t;
    endfunction

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rtc_time got_time;
        t_rtc_time want_time;
        if (!i_rst_n) begin
            dst_on = 1'b0;
            zone_hours = 5'd0;
            expected_times.delete();
        end else begin
            if (o_valid) begin
                got_time = '{second: o_second, minute: o_minute, hour: o_hour_out,
                             weekday: o_weekday_out, day: o_day_out, month: o_month_out,
                             year: o_year_out, summer: o_summer_time};
                if (expected_times.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, got_time);
                    fails++;
                end else begin
                    want_time = expected_times.pop_front();
                    check_field("second", {4'd0, want_time.second},
                                {4'd0, got_time.second});
                    check_field("minute", {4'd0, want_time.minute},
                                {4'd0, got_time.minute});
                    check_field("hour", {4'd0, want_time.hour}, {4'd0, got_time.hour});
                    check_field("weekday", {4'd0, want_time.weekday},
                                {4'd0, got_time.weekday});
                    check_field("day", {4'd0, want_time.day}, {4'd0, got_time.day});
                    check_field("month", {4'd0, want_time.month}, {4'd0, got_time.month});
                    check_field("year", want_time.year, got_time.year);
                    check_field("summer_time", {11'd0, want_time.summer},
                                {11'd0, got_time.summer});
                end
            end
            if (start && !busy) begin
                expected_times.push_back(decode_and_adjust(i_sec_bcd, i_min_bcd, i_hour_bcd,
                    i_weekday_raw, i_day_bcd, i_month_bcd, i_year_bcd));
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == brda_pkg::ADDR_DST_ENABLE) begin
                    dst_on = pwdata[0];
                end else if (paddr == brda_pkg::ADDR_ZONE_OFFSET) begin
                    zone_hours = pwdata[4:0];
                end
            end
        end
        pending = expected_times.size();
    end

endmodule

// ===== dv/tb_bcd_rtc_dst_adjust.sv =====
// Testbench top for the BCD clock decoder: drives requests and register writes, gives the verdict.
module tb_bcd_rtc_dst_adjust;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 170;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_sec_bcd;
    logic [7:0]  i_min_bcd;
    logic [7:0]  i_hour_bcd;
    logic [7:0]  i_weekday_raw;
    logic [7:0]  i_day_bcd;
    logic [7:0]  i_month_bcd;
    logic [7:0]  i_year_bcd;
    logic        o_valid;
    logic [7:0]  o_second;
    logic [7:0]  o_minute;
    logic [7:0]  o_hour_out;
    logic [7:0]  o_weekday_out;
    logic [7:0]  o_day_out;
    logic [7:0]  o_month_out;
    logic [11:0] o_year_out;
    logic        o_summer_time;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_taken = 1'b0;
    logic        apb_done = 1'b0;
    int          fail_count;
    int          pending_count;

    bit          phase_dst [PHASES] = '{0, 1, 1, 1, 1, 1, 1, 0, 1};
    int          phase_zone [PHASES] = '{0, 0, -16, 15, -12, 14, 1, -5, 0};

    bcd_rtc_dst_adjust u_top (.*);

    rtc_decode_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && start && !busy;
        apb_done <= psel && penable && pready;
    end

    function automatic logic [7:0] to_bcd(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task automatic send_request(input logic [7:0] s, m, h, w, d, mo, y);
        start <= 1'b1;
        i_sec_bcd <= s;
        i_min_bcd <= m;
        i_hour_bcd <= h;
        i_weekday_raw <= w;
        i_day_bcd <= d;
        i_month_bcd <= mo;
        i_year_bcd <= y;
        do @(negedge i_clk); while (!req_taken);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!apb_done);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input bit dst, input int zone);
        drain();
        write_reg(brda_pkg::ADDR_DST_ENABLE, {31'd0, dst});
        write_reg(brda_pkg::ADDR_ZONE_OFFSET, {27'd0, 5'(zone)});
    endtask

    task automatic random_request();
        int          kind;
        logic [7:0]  h;
        logic [7:0]  w;
        logic [7:0]  d;
        logic [7:0]  mo;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            send_request(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
            return;
        end
        if (kind < 45) begin
            mo = $urandom_range(0, 1) ? to_bcd(3) : to_bcd(10);
            d = to_bcd($urandom_range(22, 31));
            h = to_bcd($urandom_range(0, 23));
            w = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 9))
                                            : 8'($urandom_range(1, 7));
        end else if (kind < 70) begin
            mo = to_bcd($urandom_range(2, 11));
            d = to_bcd($urandom_range(28, 31));
            h = to_bcd($urandom_range(22, 23));
            w = 8'($urandom_range(1, 8));
        end else begin
            mo = to_bcd($urandom_range(1, 12));
            d = to_bcd($urandom_range(1, 31));
            h = to_bcd($urandom_range(0, 23));
            w = 8'($urandom_range(1, 7));
        end
        send_request(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)), h, w, d,
                     mo, to_bcd($urandom_range(0, 99)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_sec_bcd = 8'd0;
        i_min_bcd = 8'd0;
        i_hour_bcd = 8'd0;
        i_weekday_raw = 8'd0;
        i_day_bcd = 8'd0;
        i_month_bcd = 8'd0;
        i_year_bcd = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset settings summer time is off and nothing rolls over.
        send_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_request(8'h59, 8'h59, 8'h23, 8'd7, 8'h31, 8'h08, 8'h99);

        set_config(1'b1, 0);
        send_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_request(8'h59, 8'h59, 8'h23, 8'd7, 8'h31, 8'h08, 8'h99);
        send_request(8'h00, 8'h00, 8'h01, 8'd7, 8'h25, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h00, 8'd7, 8'h31, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h12, 8'd3, 8'h28, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h12, 8'd1, 8'h25, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h12, 8'd6, 8'h25, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h12, 8'd3, 8'h24, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h12, 8'd3, 8'h24, 8'h10, 8'h24);
        send_request(8'h00, 8'h00, 8'h00, 8'd7, 8'h27, 8'h10, 8'h24);
        send_request(8'h00, 8'h00, 8'h01, 8'd7, 8'h27, 8'h10, 8'h24);
        send_request(8'h00, 8'h00, 8'h23, 8'd6, 8'h31, 8'h10, 8'h24);
        send_request(8'h00, 8'h00, 8'h23, 8'd6, 8'h25, 8'h10, 8'h24);
        send_request(8'h00, 8'h00, 8'h23, 8'd8, 8'h31, 8'h10, 8'h24);
        send_request(8'h00, 8'h00, 8'h25, 8'd3, 8'h28, 8'h02, 8'h24);
        send_request(8'h00, 8'h00, 8'h99, 8'd2, 8'h01, 8'h03, 8'h24);
        send_request(8'h00, 8'h00, 8'h10, 8'd0, 8'h15, 8'h07, 8'h24);
        send_request(8'h00, 8'h00, 8'h23, 8'd255, 8'h31, 8'h07, 8'h24);
        send_request(8'h0a, 8'h0f, 8'haf, 8'd5, 8'h1f, 8'h0a, 8'haa);
        send_request(8'h00, 8'h00, 8'h23, 8'd3, 8'h10, 8'h1f, 8'h24);
        send_request(8'h00, 8'h00, 8'h23, 8'd255, 8'h31, 8'h12, 8'h24);
        send_request(8'h00, 8'h00, 8'h23, 8'd2, 8'h30, 8'h09, 8'h24);

        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_dst[p],
                       (p == PHASES - 1) ? int'($signed(5'($urandom))) : phase_zone[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p < PHASES - 1 && $urandom_range(0, 5) == 0) begin
                    pause($urandom_range(1, 15));
                end
                random_request();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/brda_pkg.sv
rtl/brda_adjust.sv
rtl/bcd_rtc_dst_adjust.sv
dv/rtc_decode_checker.sv
dv/tb_bcd_rtc_dst_adjust.sv
